>>> hw/rtl/jfpc_pkg.sv
// shared types and constants for the joint force pi controller
package jfpc_pkg;
	localparam int NumRegs = 8;
	localparam logic signed [31:0] GripWeight = 32'sd237876;
	localparam logic signed [31:0] ScaleOne = 32'sd65536;
	localparam logic [1:0] OP_WRENCH = 2'd0;
	localparam logic [1:0] OP_BIAS = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;
	localparam logic [2:0] REG_KP = 3'd6;
	localparam logic [2:0] REG_KI = 3'd7;
	typedef logic signed [31:0] q16_t;
	typedef logic signed [47:0] q48_t;

	function automatic q16_t sat32(input logic signed [95:0] x);
		if (x > 96'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -96'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic q48_t sat48(input logic signed [95:0] x);
		if (x > 96'sd140737488355327) begin
			return 48'sh7fffffffffff;
		end else if (x < -96'sd140737488355328) begin
			return 48'sh800000000000;
		end
		return x[47:0];
	endfunction
endpackage

>>> hw/rtl/joint_force_pi_controller_core.sv
// top level of the joint force pi controller: sequencer, shared multiplier, state memory
// one beat at a time through a single shared 33x33 multiplier; a new beat is taken only once
// the sequencer is back in idle from its wrench, tick, bias or update steps, while a bias or
// update with an out of range joint takes no step; m_tvalid rises after an update's ST_OUT
// the result waits in an output register; a later update stalls in its last step while full
// arst_n clears control state, scales to one and gains/wrench to zero; the joint
// memory is swept clear entry by entry in ST_CLR after reset, no beat taken meanwhile
module joint_force_pi_controller_core
	import jfpc_pkg::*;
#(
	parameter int NUM_JOINTS = 7,
	parameter int DELTA_TAU_MAX = 65536,
	parameter int SMOOTH_GAIN = 66
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	// joint[2:0], vec_a..vec_f, measured, gravity, last, period, zero pad to 312
	input  logic [311:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_joint[2:0], torque_command[34:3], rate_clipped[35], zero pad to 40
	output logic [39:0] m_tdata
);
	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam logic signed [32:0] Dmax = 33'(DELTA_TAU_MAX);
	localparam logic signed [32:0] Sg = 33'(SMOOTH_GAIN);
	localparam logic signed [32:0] Sr = 33'(65536 - SMOOTH_GAIN);

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_WR = 4'd2,
		ST_TK = 4'd3, ST_RD = 4'd4, ST_BIAS = 4'd5, ST_DOT = 4'd6,
		ST_E = 4'd7, ST_INT = 4'd8, ST_KP = 4'd9, ST_KIH = 4'd10,
		ST_KIL = 4'd11, ST_OUT = 4'd12, ST_TK2 = 4'd13;

	logic [3:0] st_q;
	logic [3:0] k_q;
	// opcode in the low two bits, then the tdata fields
	logic [308:0] in_q;
	q16_t tgt_q [NumRegs];
	q16_t scl_q [6];
	q16_t wr_q [6];
	q16_t kp_q, ki_q;
	// joint memory: bias in upper 32 bits, integrator in lower 48
	logic [79:0] jmem [NUM_JOINTS];
	logic [79:0] jrd_q;
	logic [JW-1:0] clr_q;
	logic signed [95:0] acc_q;
	q16_t e_q;
	q48_t integ_q;
	logic signed [65:0] prod;
	logic signed [32:0] ma, mb;
	logic [39:0] out_q;
	logic ov_q;

	logic [1:0] op;
	logic [JW-1:0] jn;
	logic [2:0] jraw;
	assign op = in_q[1:0];
	assign jraw = in_q[4:2];
	assign jn = JW'(jraw);
	function automatic q16_t fv(input logic [308:0] d, input int i);
		return d[5+32*i +: 32];
	endfunction

	q16_t wsel;
	always_comb begin
		unique case (k_q)
			4'd1: wsel = sat32(-96'(wr_q[1]));
			4'd2: wsel = sat32(-96'(wr_q[2]) + 96'(GripWeight));
			default: wsel = wr_q[k_q[2:0] < 3'd6 ? k_q[2:0] : 3'd0];
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_WR: begin
				ma = 33'(fv(in_q, int'(k_q[2:0])));
				mb = 33'(scl_q[k_q[2:0] < 3'd6 ? k_q[2:0] : 3'd0]);
			end
			ST_DOT: begin
				ma = 33'(fv(in_q, int'(k_q[2:0])));
				mb = 33'(wsel);
			end
			ST_TK: begin
				ma = Sg;
				mb = 33'(tgt_q[k_q[2:0]]);
			end
			ST_TK2: begin
				ma = Sr;
				mb = (k_q < 4'd6) ? 33'(scl_q[k_q[2:0]]) : (k_q == 4'd6 ? 33'(kp_q) : 33'(ki_q));
			end
			ST_INT: begin
				ma = {17'd0, in_q[5+32*9 +: 16]};
				mb = 33'(e_q);
			end
			ST_KP: begin
				ma = 33'(kp_q);
				mb = 33'(e_q);
			end
			ST_KIH: begin
				// upper integrator part is signed
				ma = 33'(ki_q);
				mb = 33'($signed(integ_q[47:16]));
			end
			ST_KIL: begin
				ma = 33'(ki_q);
				mb = {17'd0, integ_q[15:0]};
			end
			default: ;
		endcase
	end
	assign prod = ma * mb;

	logic signed [95:0] ext, dsum, cmd96;
	always_comb begin
		ext = 96'(fv(in_q, 6)) - 96'(fv(in_q, 7)) - 96'($signed(jrd_q[79:48]));
		cmd96 = 96'(sat32(acc_q)) - 96'(fv(in_q, 8));
		dsum = cmd96;
		if (cmd96 > 96'(Dmax)) dsum = 96'(Dmax);
		else if (cmd96 < -96'(Dmax)) dsum = -96'(Dmax);
	end

	// the output register decouples: a new beat may start while a result waits
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_CLR) begin
			jmem[clr_q] <= '0;
		end else if (st_q == ST_BIAS) begin
			jmem[jn] <= {sat32(96'(fv(in_q, 6)) - 96'(fv(in_q, 7))), 48'd0};
		end else if (st_q == ST_KP) begin
			jmem[jn] <= {jrd_q[79:48], integ_q};
		end
		jrd_q <= jmem[jn];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			k_q <= '0;
			ov_q <= 1'b0;
			in_q <= '0;
			acc_q <= '0;
			e_q <= '0;
			integ_q <= '0;
			out_q <= '0;
			for (int i = 0; i < 6; i++) begin
				tgt_q[i] <= ScaleOne;
				scl_q[i] <= ScaleOne;
				wr_q[i] <= '0;
			end
			tgt_q[6] <= '0;
			tgt_q[7] <= '0;
			kp_q <= '0;
			ki_q <= '0;
		end else begin
			if (cfg_we) tgt_q[cfg_index] <= cfg_data;
			if (ov_q && m_tready) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NUM_JOINTS - 1) st_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid && s_tready) begin
					in_q <= {s_tdata[306:0], s_tuser};
					k_q <= '0;
					acc_q <= '0;
					unique case (s_tuser)
						OP_WRENCH: st_q <= ST_WR;
						OP_TICK: st_q <= ST_TK;
						default: st_q <= (32'(s_tdata[2:0]) < NUM_JOINTS) ? ST_RD : ST_IDLE;
					endcase
				end
				ST_WR: begin
					wr_q[k_q[2:0]] <= sat32(96'(prod >>> 16));
					k_q <= k_q + 1'b1;
					if (k_q == 4'd5) st_q <= ST_IDLE;
				end
				ST_TK: begin
					acc_q <= 96'(prod);
					st_q <= ST_TK2;
				end
				ST_TK2: begin
					if (k_q < 4'd6) scl_q[k_q[2:0]] <= 32'((acc_q + 96'(prod)) >>> 16);
					else if (k_q == 4'd6) kp_q <= 32'((acc_q + 96'(prod)) >>> 16);
					else ki_q <= 32'((acc_q + 96'(prod)) >>> 16);
					k_q <= k_q + 1'b1;
					st_q <= (k_q == 4'd7) ? ST_IDLE : ST_TK;
				end
				ST_RD: st_q <= (op == OP_BIAS) ? ST_BIAS : ST_DOT;
				ST_BIAS: st_q <= ST_IDLE;
				ST_DOT: begin
					acc_q <= acc_q + 96'(prod >>> 16);
					k_q <= k_q + 1'b1;
					if (k_q == 4'd5) st_q <= ST_E;
				end
				ST_E: begin
					e_q <= sat32(96'(sat32(acc_q)) - 96'(sat32(ext)));
					acc_q <= 96'(sat32(acc_q));
					st_q <= ST_INT;
				end
				ST_INT: begin
					integ_q <= sat48(96'($signed(jrd_q[47:0])) + 96'(prod >>> 20));
					st_q <= ST_KP;
				end
				ST_KP: begin
					acc_q <= acc_q + 96'(prod >>> 16);
					st_q <= ST_KIH;
				end
				ST_KIH: begin
					acc_q <= acc_q + 96'(prod);
					st_q <= ST_KIL;
				end
				ST_KIL: begin
					acc_q <= acc_q + 96'(prod >>> 16);
					st_q <= ST_OUT;
				end
				ST_OUT: if (!ov_q) begin
					out_q <= {4'd0, (dsum != cmd96),
						sat32(96'(fv(in_q, 8)) + dsum), jraw};
					ov_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_tready) else $error("beat taken while busy");
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q) == ST_OUT) else $error("result without update");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule

>>> bench/tb_joint_force_pi_controller_core.sv
// testbench for the joint force pi controller core: predicts torque commands and checks beats
module tb_joint_force_pi_controller_core;
	import jfpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NJ = 7;
	localparam int DTAU = 65536;
	localparam int SG = 66;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] period;
		logic signed [31:0] last;
		logic signed [31:0] grav;
		logic signed [31:0] meas;
		logic signed [31:0] vf, ve, vd, vc, vb, va;
		logic [2:0] joint;
		logic [1:0] op;
	} cmd_item_t;

	typedef struct packed {
		logic clipped;
		logic signed [31:0] torque;
		logic [2:0] joint;
	} torque_cmd_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [1:0] s_tuser = '0;
	logic [311:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;

	always #6 clk = ~clk;

	joint_force_pi_controller_core u_top (.*);

	// predictor state
	longint tgt [8];
	longint wrench [6];
	longint scale [6];
	longint kp_now, ki_now;
	longint bias [NJ];
	longint integ [NJ];

	cmd_item_t pending_items [$];
	torque_cmd_t expected_cmds [$];
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	function automatic longint fsh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint clampv(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint s32(longint x);
		return clampv(x, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint smooth_step(longint t, longint v);
		return fsh(SG * t + (65536 - SG) * v, 16);
	endfunction

	// advance predicted state by one accepted beat
	task automatic predict_beat(input cmd_item_t it);
		longint v [6];
		longint w [6];
		longint acc, tau_d, tau_ext, e, ig, hi, lo, cmdv, d, last;
		logic clip;
		torque_cmd_t r;
		v[0] = it.va; v[1] = it.vb; v[2] = it.vc;
		v[3] = it.vd; v[4] = it.ve; v[5] = it.vf;
		case (it.op)
			OP_WRENCH: begin
				for (int i = 0; i < 6; i++) wrench[i] = s32(fsh(v[i] * scale[i], 16));
			end
			OP_TICK: begin
				for (int i = 0; i < 6; i++) scale[i] = smooth_step(tgt[i], scale[i]);
				kp_now = smooth_step(tgt[REG_KP], kp_now);
				ki_now = smooth_step(tgt[REG_KI], ki_now);
			end
			default: begin
				if (it.joint < NJ) begin
					if (it.op == OP_BIAS) begin
						bias[it.joint] = s32(longint'(it.meas) - it.grav);
						integ[it.joint] = 0;
					end else begin
						w[0] = wrench[0];
						w[1] = s32(-wrench[1]);
						w[2] = s32(-wrench[2] + GripWeight);
						for (int i = 3; i < 6; i++) w[i] = wrench[i];
						acc = 0;
						for (int i = 0; i < 6; i++) acc += fsh(v[i] * w[i], 16);
						tau_d = s32(acc);
						tau_ext = s32(longint'(it.meas) - it.grav - bias[it.joint]);
						e = s32(tau_d - tau_ext);
						ig = clampv(integ[it.joint] + fsh(longint'(it.period) * e, 20),
							-(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
						integ[it.joint] = ig;
						hi = fsh(ig, 16);
						lo = ig & 64'hffff;
						cmdv = s32(tau_d + fsh(kp_now * e, 16) + ki_now * hi
							+ fsh(ki_now * lo, 16));
						last = it.last;
						d = cmdv - last;
						clip = 0;
						if (d > DTAU) begin
							d = DTAU; clip = 1;
						end else if (d < -DTAU) begin
							d = -DTAU; clip = 1;
						end
						r.joint = it.joint;
						r.torque = 32'(s32(last + d));
						r.clipped = clip;
						expected_cmds.insert(expected_cmds.size(), r);
					end
				end
			end
		endcase
	endtask

	// driver: one beat from the queue, random idle gaps
	always @(posedge clk) begin
		cmd_item_t nx;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid) predict_beat(cmd_item_t'({s_tdata[306:0], s_tuser}));
				if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					nx = pending_items.pop_front();
					s_tdata <= {5'b0, nx[308:2]};
					s_tuser <= nx.op;
					s_tvalid <= 1;
				end else begin
					s_tvalid <= 0;
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		torque_cmd_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = torque_cmd_t'(m_tdata[35:0]);
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want || m_tdata[39:36] !== 4'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: joint %0d/%0d torque %0d/%0d clip %0b/%0b (exp/got)",
							want.joint, got.joint, want.torque, got.torque,
							want.clipped, got.clipped);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_q();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 262143) - 131072;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_item_t rand_item(input logic [1:0] op);
		cmd_item_t it;
		it.op = op;
		it.joint = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(NJ - 1));
		if ($urandom_range(19) == 0) it.joint = 3'($urandom);
		it.va = rand_q(); it.vb = rand_q(); it.vc = rand_q();
		it.vd = rand_q(); it.ve = rand_q(); it.vf = rand_q();
		it.meas = rand_q(); it.grav = rand_q(); it.last = rand_q();
		it.period = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1100));
		return it;
	endfunction

	// wait for the queue to drain and all results to return, then settle
	task automatic drain();
		wait (pending_items.size() == 0 && !s_tvalid);
		wait (expected_cmds.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx < NumRegs) tgt[idx] = longint'(signed'(val));
	endtask

	initial begin
		cmd_item_t it;
		int ops;
		for (int i = 0; i < 6; i++) begin
			tgt[i] = ScaleOne; wrench[i] = 0; scale[i] = ScaleOne;
		end
		tgt[REG_KP] = 0; tgt[REG_KI] = 0; kp_now = 0; ki_now = 0;
		for (int j = 0; j < NJ; j++) begin
			bias[j] = 0; integ[j] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: extremes, each op, out of range joints
		for (int k = 0; k < 8; k++)
			write_reg(3'(k), (k < 6) ? 32'h7fff_ffff : 32'h0001_0000);
		write_reg(3'd7, 32'h8000_0000);
		it = '0; it.op = OP_TICK; pending_items.insert(pending_items.size(), it);
		it = '0; it.op = OP_WRENCH; it.va = 32'h7fff_ffff; it.vb = 32'h8000_0000;
		it.vc = 32'h8000_0000; it.vd = 32'hffff_ffff; it.ve = 32'h0001_0000;
		it.vf = 32'h7fff_ffff; pending_items.insert(pending_items.size(), it);
		for (int j = 0; j < 8; j++) begin
			it = '1; it.op = OP_BIAS; it.joint = 3'(j); it.meas = 32'h7fff_ffff;
			it.grav = 32'h8000_0000; pending_items.insert(pending_items.size(), it);
			it = '1; it.op = OP_UPDATE; it.joint = 3'(j); it.period = 16'hffff;
			it.last = (j[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
			pending_items.insert(pending_items.size(), it);
		end
		it = '0; it.op = OP_UPDATE; it.joint = 3'd2; pending_items.insert(pending_items.size(), it);
		it = '0; it.op = OP_TICK; it.joint = 3'd7; pending_items.insert(pending_items.size(), it);
		drain();
		write_reg(3'd0, 32'h8000_0000);

		// random phases with settings changes between them
		for (int ph = 0; ph < 5; ph++) begin
			sender_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 27 : 0;
			receiver_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 27 : 0;
			for (int k = 0; k < 8; k++)
				case (ph)
					0: write_reg(3'(k), (k < 6) ? ScaleOne : 32'h0000_8000);
					4: write_reg(3'(k), (k < 6) ? 32'h8000_0000 : 32'h7fff_ffff);
					default: write_reg(3'(k), (k < 6) ? $urandom_range(0, 262143) - 131072
						: $urandom_range(0, 131071) - 65536);
				endcase
			for (int n = 0; n < 380; n++) begin
				ops = $urandom_range(9);
				pending_items.insert(pending_items.size(),
					rand_item(ops < 2 ? OP_WRENCH : ops < 3 ? OP_BIAS
					: ops < 8 ? OP_UPDATE : OP_TICK));
				// sender hold-off until all results are back
				if (ph == 2 && n == 190) begin
					wait (pending_items.size() == 0 && !s_tvalid);
					wait (expected_cmds.size() == 0);
				end
			end
			drain();
		end

		if (mismatches == 0 && expected_cmds.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
